// ===== rtl/lagrange_interpolation_eval_defines.svh =====
// assertion macros used by the checker file
`ifndef LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_EVAL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lie_pkg.sv =====
package lie_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int IDX_W         = 9;

    localparam logic       KIND_LOAD = 1'b0;
    localparam logic       KIND_EVAL = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_WRITE,
        DP_QUERY,
        DP_DUP,
        DP_LJ_INIT,
        DP_DIV_START,
        DP_FAC,
        DP_MUL_L,
        DP_UPD_L,
        DP_MUL_Y,
        DP_UPD_SUM
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUP_RD,
        S_DUP_CMP,
        S_EJ_START,
        S_EK_CHECK,
        S_EK_RD,
        S_EK_LOAD,
        S_EK_DIV,
        S_EK_FAC,
        S_EK_MUL,
        S_EK_UPD,
        S_TERM_RD,
        S_TERM_MUL,
        S_TERM_UPD,
        S_DONE
    } ctl_state_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
    } dp_cmd_t;

    typedef struct packed {
        logic x_equal;
        logic div_busy;
    } dp_stat_t;

    typedef struct packed {
        logic               ov;
        logic signed [31:0] val;
    } sat_t;

    // clip to signed 32 bits, flag when clipped
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        r.ov  = 1'b0;
        r.val = v[31:0];
        if (v > 64'sd2147483647)
        begin
            r.ov  = 1'b1;
            r.val = 32'sh7fff_ffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r.ov  = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

    // signed divide by 65536, truncated toward zero
    function automatic logic signed [63:0] q16_trunc(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p + (p[63] ? 64'sd65535 : 64'sd0);
        return adj >>> 16;
    endfunction

endpackage

// ===== rtl/lie_ram.sv =====
module lie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lie_datapath.sv =====
module lie_datapath #(
    parameter int MAX_NODES = lie_pkg::MAX_NODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lie_pkg::dp_cmd_t    cmd,
    output lie_pkg::dp_stat_t   stat,
    input  logic [5:0]          node_index,
    input  logic signed [31:0]  node_x,
    input  logic signed [31:0]  node_y,
    input  logic signed [31:0]  query_x,
    output logic signed [31:0]  value,
    output logic [1:0]          status
);
    import lie_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    logic [IDX_W-1:0] widx;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    ra;
    logic [AW-1:0]    rb;
    logic signed [31:0] xa;
    logic signed [31:0] xb;
    logic signed [31:0] yj;

    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] sum_reg, sum_next;
    logic signed [31:0] lj_reg, lj_next;
    logic signed [31:0] fac_reg, fac_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               ov_reg, ov_next;
    logic               dup_reg, dup_next;

    // restoring divider on magnitudes, one quotient bit a cycle
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    logic signed [32:0] num_s;
    logic signed [32:0] den_s;
    logic [32:0]        num_m;
    logic [32:0]        den_m;
    logic [32:0]        rem_sh;
    logic signed [63:0] fac_wide;
    sat_t               fac_sat;
    sat_t               lj_sat;
    sat_t               term_sat;
    sat_t               sum_sat;

    assign widx  = {{(IDX_W-6){1'b0}}, node_index};
    assign we    = (cmd.op == DP_WRITE) && (widx < IDX_W'(MAX_NODES));
    assign waddr = widx[AW-1:0];
    assign ra    = cmd.idx_a[AW-1:0];
    assign rb    = cmd.idx_b[AW-1:0];

    // two copies of the abscissae give two reads a cycle
    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xa (
        .clk(clk), .we(we), .waddr(waddr), .wdata(node_x), .raddr(ra), .rdata(xa)
    );
    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_xb (
        .clk(clk), .we(we), .waddr(waddr), .wdata(node_x), .raddr(rb), .rdata(xb)
    );
    lie_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_y (
        .clk(clk), .we(we), .waddr(waddr), .wdata(node_y), .raddr(ra), .rdata(yj)
    );

    assign stat.x_equal  = (xa == xb);
    assign stat.div_busy = busy_reg;

    assign num_s    = 33'(q_reg) - 33'(xb);
    assign den_s    = 33'(xa) - 33'(xb);
    assign num_m    = num_s[32] ? -num_s : num_s;
    assign den_m    = den_s[32] ? -den_s : den_s;
    assign rem_sh   = {rem_reg[31:0], quo_reg[47]};
    assign fac_wide = neg_reg ? -$signed({16'd0, quo_reg}) : $signed({16'd0, quo_reg});
    assign fac_sat  = sat32(fac_wide);
    assign lj_sat   = sat32(q16_trunc(prod_reg));
    assign term_sat = lj_sat;
    assign sum_sat  = sat32(64'(sum_reg) + 64'(term_sat.val));

    always_comb
    begin
        q_next    = q_reg;
        sum_next  = sum_reg;
        lj_next   = lj_reg;
        fac_next  = fac_reg;
        prod_next = prod_reg;
        ov_next   = ov_reg;
        dup_next  = dup_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;

        if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
            end
        end

        unique case (cmd.op)
            DP_QUERY:
            begin
                q_next   = query_x;
                sum_next = '0;
                ov_next  = 1'b0;
                dup_next = 1'b0;
            end
            DP_DUP:
            begin
                sum_next = '0;
                dup_next = 1'b1;
            end
            DP_LJ_INIT:
            begin
                lj_next = Q_ONE;
            end
            DP_DIV_START:
            begin
                quo_next  = {num_m[31:0], 16'd0};
                rem_next  = '0;
                dvs_next  = den_m[31:0];
                neg_next  = num_s[32] ^ den_s[32];
                cnt_next  = '0;
                busy_next = 1'b1;
            end
            DP_FAC:
            begin
                fac_next = fac_sat.val;
                ov_next  = ov_reg | fac_sat.ov;
            end
            DP_MUL_L:
            begin
                prod_next = 64'(lj_reg) * 64'(fac_reg);
            end
            DP_UPD_L:
            begin
                lj_next = lj_sat.val;
                ov_next = ov_reg | lj_sat.ov;
            end
            DP_MUL_Y:
            begin
                prod_next = 64'(lj_reg) * 64'(yj);
            end
            DP_UPD_SUM:
            begin
                sum_next = sum_sat.val;
                ov_next  = ov_reg | term_sat.ov | sum_sat.ov;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            dup_reg  <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            dup_reg  <= dup_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        lj_reg   <= lj_next;
        fac_reg  <= fac_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
    end

    assign value  = sum_reg;
    assign status = dup_reg ? ST_DUP : (ov_reg ? ST_OVF : ST_OK);

endmodule

// ===== rtl/lie_ctrl.sv =====
module lie_ctrl #(
    parameter int MAX_NODES = lie_pkg::MAX_NODES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_data,
    output lie_pkg::dp_cmd_t  cmd,
    input  lie_pkg::dp_stat_t stat
);
    import lie_pkg::*;

    localparam int CW = $clog2(MAX_NODES + 2);

    ctl_state_t state_reg, state_next;
    logic [6:0]    count_reg;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [IDX_W-1:0] count_w;
    logic [CW-1:0]    n;

    // node count clipped to the store depth
    assign count_w = {{(IDX_W-7){1'b0}}, count_reg};
    assign n = (count_w > IDX_W'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(count_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= 7'd1;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd.op     = DP_NONE;
        cmd.idx_a  = IDX_W'(j_reg);
        cmd.idx_b  = IDX_W'(k_reg);
        in_stall   = (state_reg != S_IDLE);
        out_valid  = (state_reg == S_DONE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        cmd.op = DP_WRITE;
                    end
                    else
                    begin
                        cmd.op = DP_QUERY;
                        j_next = '0;
                        k_next = CW'(1);
                        if (n == '0)
                            state_next = S_DONE;
                        else if (n == CW'(1))
                            state_next = S_EJ_START;
                        else
                            state_next = S_DUP_RD;
                    end
                end
            end
            S_DUP_RD:
            begin
                state_next = S_DUP_CMP;
            end
            S_DUP_CMP:
            begin
                if (stat.x_equal)
                begin
                    cmd.op     = DP_DUP;
                    state_next = S_DONE;
                end
                else if (k_reg + CW'(1) < n)
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_DUP_RD;
                end
                else if (j_reg + CW'(2) < n)
                begin
                    j_next     = j_reg + CW'(1);
                    k_next     = j_reg + CW'(2);
                    state_next = S_DUP_RD;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_EJ_START;
                end
            end
            S_EJ_START:
            begin
                cmd.op     = DP_LJ_INIT;
                k_next     = '0;
                state_next = S_EK_CHECK;
            end
            S_EK_CHECK:
            begin
                if (k_reg == n)
                    state_next = S_TERM_RD;
                else if (k_reg == j_reg)
                    k_next = k_reg + CW'(1);
                else
                    state_next = S_EK_RD;
            end
            S_EK_RD:
            begin
                state_next = S_EK_LOAD;
            end
            S_EK_LOAD:
            begin
                cmd.op     = DP_DIV_START;
                state_next = S_EK_DIV;
            end
            S_EK_DIV:
            begin
                if (!stat.div_busy)
                    state_next = S_EK_FAC;
            end
            S_EK_FAC:
            begin
                cmd.op     = DP_FAC;
                state_next = S_EK_MUL;
            end
            S_EK_MUL:
            begin
                cmd.op     = DP_MUL_L;
                state_next = S_EK_UPD;
            end
            S_EK_UPD:
            begin
                cmd.op     = DP_UPD_L;
                k_next     = k_reg + CW'(1);
                state_next = S_EK_CHECK;
            end
            S_TERM_RD:
            begin
                state_next = S_TERM_MUL;
            end
            S_TERM_MUL:
            begin
                cmd.op     = DP_MUL_Y;
                state_next = S_TERM_UPD;
            end
            S_TERM_UPD:
            begin
                cmd.op = DP_UPD_SUM;
                j_next = j_reg + CW'(1);
                if (j_reg + CW'(1) == n)
                    state_next = S_DONE;
                else
                    state_next = S_EJ_START;
            end
            S_DONE:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lagrange_interpolation_eval.sv =====
// lagrange interpolation evaluator, signed q16.16. a load request (kind 0) writes node
// (node_x, node_y) into slot node_index and gives no result; slots at or above
// MAX_NODES are dropped. an evaluate request (kind 1) gives one result: the polynomial
// through nodes 0 .. node_count-1 (clipped to MAX_NODES) at query_x. every slot in use
// must have been loaded first. status is 0 ok, 1 when two nodes in use share an
// abscissa (value is then 0), 2 when any step saturated. one request at a time: a
// query checks the P = n(n-1)/2 pairs for a shared abscissa and, if none, forms n(n-1)
// factors, each through the bit-serial 48-step divider, then one term per node.
// node_count must be written only while idle; the block itself does not enforce it.
module lagrange_interpolation_eval #(
    parameter int MAX_NODES = lie_pkg::MAX_NODES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [5:0]         node_index,
    input  logic signed [31:0] node_x,
    input  logic signed [31:0] node_y,
    input  logic signed [31:0] query_x,
    // result channel, held until taken
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic [1:0]         status,
    // node_count register
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data
);
    import lie_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: duplicate scan, then j outer / k inner factor loop
    lie_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // node stores, divider, multiplier and accumulator
    lie_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .node_index (node_index),
        .node_x     (node_x),
        .node_y     (node_y),
        .query_x    (query_x),
        .value      (value),
        .status     (status)
    );

endmodule

// ===== rtl/lie_checker.sv =====
`include "lagrange_interpolation_eval_defines.svh"

module lie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] value,
    input logic [1:0]  status
);
    import lie_pkg::*;

    `LIE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(status), "result changed while stalled")
    `LIE_ASSERT_NOW(a_status_code, out_valid, status == ST_OK || status == ST_DUP || status == ST_OVF, "bad status code")
    `LIE_ASSERT_NOW(a_dup_zero, out_valid && status == ST_DUP, value == '0, "duplicate result not zero")
    `LIE_ASSERT_NOW(a_busy_while_result, out_valid, in_stall, "request taken while result pending")

endmodule

bind lagrange_interpolation_eval lie_checker u_lie_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
);
